// ===== rtl/mrta_pkg.sv =====
// Shared types and constants for the memory region table allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrta_pkg;
	localparam int TABLE_DEPTH = 512;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PAGE_SHIFT = 21;

	localparam logic [63:0] LOW_LIMIT = 64'd16 << 20;
	localparam logic [63:0] MIN_END = 64'd18 << 20;
	localparam logic [63:0] HIGH_LIMIT = 64'd1 << 48;
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_MARK = 3'd1;
	localparam logic [2:0] CMD_ALLOC = 3'd2;
	localparam logic [2:0] CMD_READ = 3'd3;
	localparam logic [2:0] CMD_COUNT = 3'd4;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_FULL = 3'd1;
	localparam logic [2:0] ERR_OUTSIDE = 3'd2;
	localparam logic [2:0] ERR_EMPTY = 3'd3;
	localparam logic [2:0] ERR_TYPE = 3'd4;
	localparam logic [2:0] ERR_SIZE = 3'd5;
	localparam logic [2:0] ERR_NOFIT = 3'd6;

	localparam logic [1:0] WR_APPEND = 2'd0;
	localparam logic [1:0] WR_SHIFT = 2'd1;
	localparam logic [1:0] WR_SLOT = 2'd2;

	typedef struct packed {
		logic [48:0] base;
		logic [48:0] size;
		logic [1:0] rtype;
	} entry_t;

	typedef struct packed {
		logic rdy;
		logic latch;
		logic rd_en;
		logic rd_j;
		logic wr_en;
		logic [1:0] wr_sel;
		logic j_clr;
		logic j_top;
		logic j_inc;
		logic j_dec;
		logic k_clr;
		logic k_inc;
		logic calc;
		logic pg_acc;
		logic fit_take;
		logic ent_take;
		logic set_err;
		logic [2:0] err;
		logic set_app;
		logic set_entry;
		logic set_addr;
		logic cnt_inc1;
		logic cnt_add_need;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic [2:0] cmd;
		logic idx_ok;
		logic full;
		logic cnt_zero;
		logic app_ok;
		logic alloc_bad;
		logic [2:0] mchk_err;
		logic fit;
		logic scan_last;
		logic shift_more;
		logic k_last;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/mrta_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mrta_req_if;
	logic valid;
	logic ready;
	logic [2:0] cmd;
	logic [63:0] raw_base;
	logic [63:0] raw_length;
	logic [31:0] firmware_type;
	logic [8:0] entry_index;
	logic [48:0] range_start;
	logic [48:0] range_end;
	logic [1:0] region_type;
	logic [48:0] request_size;
	logic [5:0] align_log2;
	modport source(output valid, cmd, raw_base, raw_length, firmware_type, entry_index,
		range_start, range_end, region_type, request_size, align_log2, input ready);
	modport sink(input valid, cmd, raw_base, raw_length, firmware_type, entry_index,
		range_start, range_end, region_type, request_size, align_log2, output ready);
endinterface

interface mrta_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] error_code;
	logic appended;
	logic [48:0] alloc_address;
	logic [48:0] entry_base;
	logic [48:0] entry_size;
	logic [1:0] entry_type;
	logic [9:0] entry_count;
	logic [27:0] free_page_count;
	modport source(output valid, error_code, appended, alloc_address, entry_base,
		entry_size, entry_type, entry_count, free_page_count, input ready);
	modport sink(input valid, error_code, appended, alloc_address, entry_base,
		entry_size, entry_type, entry_count, free_page_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrta_datapath.sv =====
// Datapath: region table memory, command registers, arithmetic, result register.
// Depends on mrta_pkg and mrta_if.
`timescale 1ns / 1ps
`default_nettype none
module mrta_datapath import mrta_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctl_t ctl,
	output sts_t sts,
	mrta_req_if.sink req,
	mrta_rsp_if.source rsp
);
	entry_t mem [TABLE_DEPTH];
	entry_t rd_q, ent_q, wd;
	logic [IDX_W-1:0] ra, wa;

	logic [2:0] cmd_q;
	logic [63:0] raw_start_q, raw_end_q;
	logic fw_ok_q;
	logic [IDX_W-1:0] tgt_q;
	logic [48:0] m_start_q, m_end_q, size_q, bend_q;
	logic [1:0] rtype_q;
	logic [5:0] p_q;
	logic [49:0] ab_q, end_q;
	logic free_q;

	logic [CNT_W-1:0] count_q, j_q;
	logic [1:0] k_q;

	logic [2:0] err_w_q;
	logic app_w_q;
	logic [48:0] addr_w_q;
	entry_t ent_w_q;
	logic [27:0] pages_q;

	logic out_valid_q;
	logic [2:0] o_err_q;
	logic o_app_q;
	logic [48:0] o_addr_q;
	entry_t o_ent_q;
	logic [9:0] o_count_q;
	logic [27:0] o_pages_q;

	// append clipping
	logic app_in;
	logic [63:0] st_up, ap_start, ap_end, ap_size;
	always_comb begin
		app_in = fw_ok_q && !(raw_end_q < MIN_END || raw_start_q >= HIGH_LIMIT);
		st_up = ((raw_start_q - 64'd1) & ~PAGE_MASK) + (PAGE_MASK + 64'd1);
		ap_start = (raw_start_q <= LOW_LIMIT) ? LOW_LIMIT : st_up;
		ap_end = (raw_end_q >= HIGH_LIMIT) ? HIGH_LIMIT : (raw_end_q & ~PAGE_MASK);
		ap_size = ap_end - ap_start;
	end

	// scan: aligned base of entry; count uses the page size as alignment
	logic [5:0] ul;
	logic [49:0] base50, ab, diff;
	logic [27:0] e_pg, s_pg;
	always_comb begin
		ul = (cmd_q == CMD_COUNT) ? 6'(PAGE_SHIFT) : p_q;
		base50 = {1'b0, rd_q.base};
		ab = ((base50 - 50'd1) & ({50{1'b1}} << ul)) + (50'd1 << ul);
		diff = end_q - ab_q;
		e_pg = end_q[48:21];
		s_pg = ab_q[48:21];
	end

	// mark checks
	logic [1:0] need;
	logic same;
	logic [CNT_W:0] room;
	logic [2:0] mchk;
	always_comb begin
		same = (m_start_q == ent_q.base);
		need = {1'b0, !same} + {1'b0, m_end_q != bend_q};
		room = {1'b0, count_q} + {{(CNT_W-1){1'b0}}, need};
		if (m_start_q < ent_q.base || m_end_q > bend_q)
			mchk = ERR_OUTSIDE;
		else if (m_end_q <= m_start_q)
			mchk = ERR_EMPTY;
		else if (rtype_q == 2'd0)
			mchk = ERR_TYPE;
		else if (room > (CNT_W+1)'(TABLE_DEPTH))
			mchk = ERR_FULL;
		else
			mchk = ERR_OK;
	end

	// write address and data
	always_comb begin
		wa = tgt_q + IDX_W'(k_q);
		wd = rd_q;
		case (ctl.wr_sel)
			WR_APPEND: begin
				wa = count_q[IDX_W-1:0];
				wd = '{base: ap_start[48:0], size: ap_size[48:0], rtype: 2'd0};
			end
			WR_SHIFT: begin
				wa = j_q[IDX_W-1:0] + IDX_W'(need);
				wd = rd_q;
			end
			default: begin
				case (k_q)
					2'd0: wd = same ? '{ent_q.base, m_end_q - ent_q.base, rtype_q}
						: '{ent_q.base, m_start_q - ent_q.base, ent_q.rtype};
					2'd1: wd = same ? '{m_end_q, bend_q - m_end_q, 2'd0}
						: '{m_start_q, m_end_q - m_start_q, rtype_q};
					default: wd = '{m_end_q, bend_q - m_end_q, 2'd0};
				endcase
			end
		endcase
		ra = ctl.rd_j ? j_q[IDX_W-1:0] : tgt_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem[wa] <= wd;
		if (ctl.rd_en)
			rd_q <= mem[ra];
	end

	// command and working registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= req.cmd;
			raw_start_q <= req.raw_base;
			raw_end_q <= req.raw_base + req.raw_length;
			fw_ok_q <= (req.firmware_type == 32'd1);
			tgt_q <= req.entry_index;
			m_start_q <= req.range_start;
			m_end_q <= req.range_end;
			rtype_q <= req.region_type;
			size_q <= req.request_size;
			p_q <= req.align_log2;
			err_w_q <= ERR_OK;
			app_w_q <= 1'b0;
			addr_w_q <= '0;
			ent_w_q <= '0;
			pages_q <= '0;
		end
		if (ctl.calc) begin
			ab_q <= ab;
			end_q <= base50 + {1'b0, rd_q.size};
			free_q <= (rd_q.rtype == 2'd0);
		end
		if (ctl.pg_acc && free_q && e_pg > s_pg)
			pages_q <= pages_q + (e_pg - s_pg);
		if (ctl.fit_take) begin
			tgt_q <= j_q[IDX_W-1:0];
			m_start_q <= ab_q[48:0];
			m_end_q <= ab_q[48:0] + size_q;
		end
		if (ctl.ent_take) begin
			ent_q <= rd_q;
			bend_q <= rd_q.base + rd_q.size;
		end
		if (ctl.set_err)
			err_w_q <= ctl.err;
		if (ctl.set_app)
			app_w_q <= 1'b1;
		if (ctl.set_entry)
			ent_w_q <= rd_q;
		if (ctl.set_addr)
			addr_w_q <= m_start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (ctl.cnt_inc1)
				count_q <= count_q + CNT_W'(1);
			else if (ctl.cnt_add_need)
				count_q <= count_q + CNT_W'(need);
			if (ctl.j_clr)
				j_q <= '0;
			else if (ctl.j_top)
				j_q <= count_q - CNT_W'(1);
			else if (ctl.j_inc)
				j_q <= j_q + CNT_W'(1);
			else if (ctl.j_dec)
				j_q <= j_q - CNT_W'(1);
			if (ctl.k_clr)
				k_q <= '0;
			else if (ctl.k_inc)
				k_q <= k_q + 2'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			o_err_q <= err_w_q;
			o_app_q <= app_w_q;
			o_addr_q <= addr_w_q;
			o_ent_q <= ent_w_q;
			o_count_q <= 10'(count_q);
			o_pages_q <= pages_q;
		end
	end

	assign req.ready = ctl.rdy;
	assign rsp.valid = out_valid_q;
	assign rsp.error_code = o_err_q;
	assign rsp.appended = o_app_q;
	assign rsp.alloc_address = o_addr_q;
	assign rsp.entry_base = o_ent_q.base;
	assign rsp.entry_size = o_ent_q.size;
	assign rsp.entry_type = o_ent_q.rtype;
	assign rsp.entry_count = o_count_q;
	assign rsp.free_page_count = o_pages_q;

	always_comb begin
		sts.in_valid = req.valid;
		sts.cmd = cmd_q;
		sts.idx_ok = {1'b0, tgt_q} < count_q;
		sts.full = count_q >= CNT_W'(TABLE_DEPTH);
		sts.cnt_zero = (count_q == '0);
		sts.app_ok = app_in && (ap_end > ap_start);
		sts.alloc_bad = (size_q == '0) || (p_q < 6'd3);
		sts.mchk_err = mchk;
		sts.fit = free_q && (p_q < 6'd49) && (end_q > ab_q) && (diff >= {1'b0, size_q});
		sts.scan_last = (j_q + CNT_W'(1) == count_q);
		sts.shift_more = j_q > {1'b0, tgt_q};
		sts.k_last = (k_q == need);
		sts.out_free = !out_valid_q || rsp.ready;
	end
endmodule
`default_nettype wire

// ===== rtl/mrta_ctrl.sv =====
// Controller state machine: sequences table scans, entry shifts and writes.
// Depends on mrta_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrta_ctrl import mrta_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire sts_t sts,
	output ctl_t ctl
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DISP = 4'd1;
	localparam logic [3:0] ST_R_WAIT = 4'd2;
	localparam logic [3:0] ST_M_WAIT = 4'd3;
	localparam logic [3:0] ST_M_CHK = 4'd4;
	localparam logic [3:0] ST_SH_RD = 4'd5;
	localparam logic [3:0] ST_SH_WR = 4'd6;
	localparam logic [3:0] ST_WS = 4'd7;
	localparam logic [3:0] ST_SC_RD = 4'd8;
	localparam logic [3:0] ST_SC_CALC = 4'd9;
	localparam logic [3:0] ST_SC_CMP = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		ctl = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				ctl.rdy = 1'b1;
				if (sts.in_valid) begin
					ctl.latch = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				state_d = ST_DONE;
				case (sts.cmd)
					CMD_APPEND: begin
						if (sts.app_ok) begin
							if (sts.full) begin
								ctl.set_err = 1'b1;
								ctl.err = ERR_FULL;
							end else begin
								ctl.wr_en = 1'b1;
								ctl.wr_sel = WR_APPEND;
								ctl.cnt_inc1 = 1'b1;
								ctl.set_app = 1'b1;
							end
						end
					end
					CMD_MARK, CMD_READ: begin
						if (!sts.idx_ok) begin
							ctl.set_err = 1'b1;
							ctl.err = ERR_NOFIT;
						end else begin
							ctl.rd_en = 1'b1;
							state_d = (sts.cmd == CMD_MARK) ? ST_M_WAIT : ST_R_WAIT;
						end
					end
					CMD_ALLOC: begin
						if (sts.alloc_bad) begin
							ctl.set_err = 1'b1;
							ctl.err = ERR_SIZE;
						end else if (sts.cnt_zero) begin
							ctl.set_err = 1'b1;
							ctl.err = ERR_NOFIT;
						end else begin
							ctl.j_clr = 1'b1;
							state_d = ST_SC_RD;
						end
					end
					CMD_COUNT: begin
						if (!sts.cnt_zero) begin
							ctl.j_clr = 1'b1;
							state_d = ST_SC_RD;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_R_WAIT: begin
				ctl.set_entry = 1'b1;
				state_d = ST_DONE;
			end
			ST_M_WAIT: begin
				ctl.ent_take = 1'b1;
				state_d = ST_M_CHK;
			end
			ST_M_CHK: begin
				if (sts.mchk_err != ERR_OK) begin
					ctl.set_err = 1'b1;
					ctl.err = sts.mchk_err;
					state_d = ST_DONE;
				end else begin
					ctl.set_addr = (sts.cmd == CMD_ALLOC);
					ctl.j_top = 1'b1;
					state_d = ST_SH_RD;
				end
			end
			ST_SH_RD: begin
				// move later entries up, top one first
				if (sts.shift_more) begin
					ctl.rd_en = 1'b1;
					ctl.rd_j = 1'b1;
					state_d = ST_SH_WR;
				end else begin
					ctl.k_clr = 1'b1;
					state_d = ST_WS;
				end
			end
			ST_SH_WR: begin
				ctl.wr_en = 1'b1;
				ctl.wr_sel = WR_SHIFT;
				ctl.j_dec = 1'b1;
				state_d = ST_SH_RD;
			end
			ST_WS: begin
				ctl.wr_en = 1'b1;
				ctl.wr_sel = WR_SLOT;
				if (sts.k_last) begin
					ctl.cnt_add_need = 1'b1;
					state_d = ST_DONE;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			ST_SC_RD: begin
				ctl.rd_en = 1'b1;
				ctl.rd_j = 1'b1;
				state_d = ST_SC_CALC;
			end
			ST_SC_CALC: begin
				ctl.calc = 1'b1;
				state_d = ST_SC_CMP;
			end
			ST_SC_CMP: begin
				if (sts.cmd == CMD_ALLOC && sts.fit) begin
					ctl.fit_take = 1'b1;
					state_d = ST_M_WAIT;
				end else begin
					ctl.pg_acc = (sts.cmd == CMD_COUNT);
					if (sts.scan_last) begin
						ctl.set_err = (sts.cmd == CMD_ALLOC);
						ctl.err = ERR_NOFIT;
						state_d = ST_DONE;
					end else begin
						ctl.j_inc = 1'b1;
						state_d = ST_SC_RD;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/memory_region_table_allocator_top.sv =====
// Append, read and unknown commands need no scan; mark moves each later entry up (a read, then a write).
// Allocate and count scan entries one at a time (read, calc, compare) through the table memory's
// single read port; allocate then runs the mark sequence.
// One word in flight; the next word is taken while a finished result waits.
// Reset (arst_n, async low) empties the table; entries are never cleared.
// Depends on mrta_pkg, mrta_if, mrta_ctrl and mrta_datapath.
`timescale 1ns / 1ps
`default_nettype none
module memory_region_table_allocator_top import mrta_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	mrta_req_if.sink req,
	mrta_rsp_if.source rsp
);
	ctl_t ctl;
	sts_t sts;

	mrta_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.ctl(ctl)
	);

	mrta_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts),
		.req(req),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	a_app_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.appended |-> rsp.error_code == ERR_OK)
		else $error("appended with error");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= 10'(TABLE_DEPTH))
		else $error("entry count beyond depth");
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second word taken while busy");
`endif
endmodule
`default_nettype wire
